### src/assert_macros.svh
// assertion helpers shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### src/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants and types of the byte signature scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int MAX_SIG_LEN        = 16;
   localparam int OFFSET_BITS        = 32;
   localparam int WIN_DEPTH          = MAX_SIG_LEN - 1;
   localparam int SIG_IDX_BITS       = $clog2(MAX_SIG_LEN);
   localparam int LEN_BITS           = 5;
   localparam int SKIP_BITS          = 8;
   localparam int CSR_DATA_BITS      = 64;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int RESULT_OFFSET_BITS = 32;

   localparam logic [CSR_DATA_BITS-1:0] SIG_LOW_RESET    = 64'd559903;
   localparam logic [CSR_DATA_BITS-1:0] SIG_HIGH_RESET   = 64'd0;
   localparam logic [LEN_BITS-1:0]      SIG_LENGTH_RESET = 5'd3;
   localparam logic [SKIP_BITS-1:0]     SKIP_RESET       = 8'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SIG_LOW    = 3'd0,
      REG_SIG_HIGH   = 3'd1,
      REG_SIG_LENGTH = 3'd2,
      REG_SKIP_COUNT = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [MAX_SIG_LEN-1:0][7:0] sig_bytes;
      logic [SIG_IDX_BITS-1:0]     len_m1;
      logic [SKIP_BITS-1:0]        skip_count;
   } cfg_type;

   typedef struct packed {
      logic       step;
      logic       last;
      logic [7:0] data_byte;
   } step_type;

   typedef struct packed {
      logic                   hit;
      logic [OFFSET_BITS-1:0] start;
   } match_type;

endpackage

### src/bss_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_csr
// Configuration registers and the clamped signature length.
// ----------------------------------------------------------------------------
module bss_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [bss_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bss_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   output bss_pkg::cfg_type                      cfg
);

   logic [bss_pkg::CSR_DATA_BITS-1:0] sig_low_ff, sig_low_in;
   logic [bss_pkg::CSR_DATA_BITS-1:0] sig_high_ff, sig_high_in;
   logic [bss_pkg::LEN_BITS-1:0]      sig_length_ff, sig_length_in;
   logic [bss_pkg::SKIP_BITS-1:0]     skip_ff, skip_in;

   always_comb begin
      sig_low_in    = sig_low_ff;
      sig_high_in   = sig_high_ff;
      sig_length_in = sig_length_ff;
      skip_in       = skip_ff;
      if (csr_write_enable) begin
         unique case (bss_pkg::csr_index_type'(csr_index))
            bss_pkg::REG_SIG_LOW:    sig_low_in    = csr_write_data;
            bss_pkg::REG_SIG_HIGH:   sig_high_in   = csr_write_data;
            bss_pkg::REG_SIG_LENGTH: sig_length_in = csr_write_data[bss_pkg::LEN_BITS-1:0];
            bss_pkg::REG_SKIP_COUNT: skip_in       = csr_write_data[bss_pkg::SKIP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_low_ff    <= bss_pkg::SIG_LOW_RESET;
         sig_high_ff   <= bss_pkg::SIG_HIGH_RESET;
         sig_length_ff <= bss_pkg::SIG_LENGTH_RESET;
         skip_ff       <= bss_pkg::SKIP_RESET;
      end else begin
         sig_low_ff    <= sig_low_in;
         sig_high_ff   <= sig_high_in;
         sig_length_ff <= sig_length_in;
         skip_ff       <= skip_in;
      end
   end

   // length zero acts as one, lengths above the maximum act as the maximum
   always_comb begin
      cfg.sig_bytes  = {sig_high_ff, sig_low_ff};
      cfg.skip_count = skip_ff;
      priority if (sig_length_ff == '0) begin
         cfg.len_m1 = '0;
      end else if (sig_length_ff > bss_pkg::LEN_BITS'(bss_pkg::MAX_SIG_LEN)) begin
         cfg.len_m1 = bss_pkg::SIG_IDX_BITS'(bss_pkg::MAX_SIG_LEN - 1);
      end else begin
         cfg.len_m1 = bss_pkg::SIG_IDX_BITS'(sig_length_ff - bss_pkg::LEN_BITS'(1));
      end
   end

endmodule

### src/bss_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_window
// Byte window, saturating byte position and parallel signature compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bss_window (
   input  logic               clock,
   input  logic               reset,
   input  bss_pkg::cfg_type   cfg,
   input  bss_pkg::step_type  step,
   output bss_pkg::match_type match
);

   logic [7:0]                     window_ff [bss_pkg::WIN_DEPTH];
   logic [7:0]                     window_in [bss_pkg::WIN_DEPTH];
   logic [bss_pkg::OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [bss_pkg::MAX_SIG_LEN-1:0] eq;
   logic                           pos_ok;

   // signature byte j sits in window slot len-2-j, the last one is the current byte
   always_comb begin
      for (int j = 0; j < bss_pkg::MAX_SIG_LEN; j++) begin
         if (bss_pkg::SIG_IDX_BITS'(j) == cfg.len_m1) begin
            eq[j] = (step.data_byte == cfg.sig_bytes[j]);
         end else if (bss_pkg::SIG_IDX_BITS'(j) < cfg.len_m1) begin
            eq[j] = (window_ff[cfg.len_m1 - bss_pkg::SIG_IDX_BITS'(j)
                               - bss_pkg::SIG_IDX_BITS'(1)] == cfg.sig_bytes[j]);
         end else begin
            eq[j] = 1'b1;
         end
      end
   end

   // window slots below len-1 are filled once the position reaches len-1
   assign pos_ok = (pos_ff >= bss_pkg::OFFSET_BITS'(cfg.len_m1)) && (pos_ff != '1);

   assign match.hit   = pos_ok && (&eq);
   assign match.start = pos_ff - bss_pkg::OFFSET_BITS'(cfg.len_m1);

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      if (step.step) begin
         if (step.last) begin
            pos_in = '0;
         end else begin
            window_in[0] = step.data_byte;
            for (int k = 1; k < bss_pkg::WIN_DEPTH; k++) begin
               window_in[k] = window_ff[k-1];
            end
            if (pos_ff != '1) begin
               pos_in = pos_ff + bss_pkg::OFFSET_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `ASSERT_PROP(a_pos_restart, clock, reset, (step.step && step.last) |=> (pos_ff == '0), "position not cleared after last byte")
   `ASSERT_PROP(a_pos_monotonic, clock, reset, (step.step && !step.last) |=> (pos_ff >= $past(pos_ff)), "position went backward within an image")

endmodule

### src/byte_signature_scanner_top.sv
`timescale 1ns / 1ps
// a request's result passes the input register, then the result register, before it is valid
// throughput: one byte per cycle while the result register is free; all window compares run in parallel
// a waiting result holds the input register; once that is full no new request is accepted
// reset: synchronous, active high; clears position, match count, flags and valids,
// and loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// byte_signature_scanner_top
// Scans an image byte stream for a configured signature and reports the
// start offset of the selected match, or a not-found result at image end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_signature_scanner_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_data_byte,
   input  logic                                     req_last_byte,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_found,
   output logic [bss_pkg::RESULT_OFFSET_BITS-1:0]   rsp_match_offset,
   input  logic                                     csr_write_enable,
   input  logic [bss_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [bss_pkg::CSR_DATA_BITS-1:0]        csr_write_data
);

   bss_pkg::cfg_type   cfg;
   bss_pkg::step_type  step;
   bss_pkg::match_type match;

   logic                                   s1_valid_ff, s1_valid_in;
   logic [7:0]                             s1_data_ff, s1_data_in;
   logic                                   s1_last_ff, s1_last_in;
   logic [bss_pkg::SKIP_BITS-1:0]          hit_count_ff, hit_count_in;
   logic                                   reported_ff, reported_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_found_ff, rsp_found_in;
   logic [bss_pkg::RESULT_OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;
   logic                                   advance;
   logic                                   report_now;
   logic                                   emit;

   bss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bss_window u_window (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .match (match)
   );

   // the input register moves on whenever the result register is free
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   assign step.step      = s1_valid_ff && advance;
   assign step.last      = s1_last_ff;
   assign step.data_byte = s1_data_ff;

   assign report_now = step.step && match.hit && !reported_ff
                       && (hit_count_ff >= cfg.skip_count);
   assign emit       = report_now || (step.step && s1_last_ff && !reported_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      hit_count_in = hit_count_ff;
      reported_in  = reported_ff;
      if (step.step) begin
         if (report_now) begin
            reported_in = 1'b1;
         end else if (match.hit && !reported_ff && (hit_count_ff != '1)) begin
            hit_count_in = hit_count_ff + bss_pkg::SKIP_BITS'(1);
         end
         if (s1_last_ff) begin
            hit_count_in = '0;
            reported_in  = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = report_now;
         rsp_offset_in = report_now ? bss_pkg::RESULT_OFFSET_BITS'(match.start) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         hit_count_ff <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         hit_count_ff <= hit_count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff    <= s1_data_in;
      s1_last_ff    <= s1_last_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   `ASSERT_NEVER(a_no_second_report, clock, reset, report_now && reported_ff,
      "second match reported within one image")
   `ASSERT_PROP(a_image_clear, clock, reset,
      (step.step && s1_last_ff) |=> (hit_count_ff == '0 && !reported_ff),
      "state not cleared after last byte")
   `ASSERT_PROP(a_reported_sticks, clock, reset,
      (step.step && reported_ff && !s1_last_ff) |=> reported_ff,
      "reported flag dropped within an image")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, emit && rsp_valid_ff && !rsp_ready,
      "result register overwritten while full")

endmodule

### tb/tb_byte_signature_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_signature_scanner_top
// Streams byte images through the scanner under random sender gaps and
// receiver stalls. A tracker of the scan state predicts every
// found / not-found result, which is checked in order against the rsp channel
// across several signature, length and skip settings.
// ----------------------------------------------------------------------------
module tb_byte_signature_scanner_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1250;
   localparam int SETTLE      = 6;
   localparam int PHASE_ITEMS = 110;

   typedef struct {
      logic                                   found;
      logic [bss_pkg::RESULT_OFFSET_BITS-1:0] offset;
   } scan_verdict_type;

   // tracks the scan state and holds the verdicts still to come out
   class signature_tracker;
      logic [bss_pkg::CSR_DATA_BITS-1:0] sig_low;
      logic [bss_pkg::CSR_DATA_BITS-1:0] sig_high;
      logic [bss_pkg::LEN_BITS-1:0]      sig_len;
      logic [bss_pkg::SKIP_BITS-1:0]     skip;
      logic [7:0]                        window [bss_pkg::WIN_DEPTH];
      logic [bss_pkg::OFFSET_BITS-1:0]   position;
      logic [bss_pkg::SKIP_BITS-1:0]     hit_count;
      bit                                reported;
      scan_verdict_type                  pending_verdicts [$];
      int                                errors;
      int                                found_count;
      int                                missing_count;

      function new();
         sig_low       = bss_pkg::SIG_LOW_RESET;
         sig_high      = bss_pkg::SIG_HIGH_RESET;
         sig_len       = bss_pkg::SIG_LENGTH_RESET;
         skip          = bss_pkg::SKIP_RESET;
         errors        = 0;
         found_count   = 0;
         missing_count = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         foreach (window[i]) window[i] = 8'h00;
         position  = '0;
         hit_count = '0;
         reported  = 1'b0;
      endfunction

      function void set_reg(bss_pkg::csr_index_type idx,
                            logic [bss_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            bss_pkg::REG_SIG_LOW:    sig_low  = value;
            bss_pkg::REG_SIG_HIGH:   sig_high = value;
            bss_pkg::REG_SIG_LENGTH: sig_len  = value[bss_pkg::LEN_BITS-1:0];
            bss_pkg::REG_SKIP_COUNT: skip     = value[bss_pkg::SKIP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] sig_at(int j);
         if (j < 8) return sig_low[8*j +: 8];
         return sig_high[8*(j-8) +: 8];
      endfunction

      // zero counts as one, anything above the maximum counts as the maximum
      function int used_len();
         int n;
         n = sig_len;
         if (n == 0) n = 1;
         if (n > bss_pkg::MAX_SIG_LEN) n = bss_pkg::MAX_SIG_LEN;
         return n;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      function void predict_byte(logic [7:0] d, logic last);
         int               len;
         bit               hit;
         scan_verdict_type v;
         len = used_len();
         hit = 1'b0;
         // no match may start before byte zero, none while the position is pinned
         if (!reported && position >= 32'(len - 1) && position != '1) begin
            hit = (sig_at(len - 1) == d);
            for (int j = 0; j + 1 < len; j++)
               if (window[len - 2 - j] != sig_at(j)) hit = 1'b0;
         end
         if (hit) begin
            if (hit_count >= skip) begin
               v.found  = 1'b1;
               v.offset = position - 32'(len - 1);
               pending_verdicts.push_back(v);
               reported = 1'b1;
            end else if (hit_count != '1) begin
               hit_count++;
            end
         end
         if (last) begin
            if (!reported) begin
               v.found  = 1'b0;
               v.offset = '0;
               pending_verdicts.push_back(v);
            end
            clear_scan();
            return;
         end
         for (int k = bss_pkg::WIN_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
         window[0] = d;
         if (position != '1) position++;
      endfunction

      function void check_verdict(logic found,
                                  logic [bss_pkg::RESULT_OFFSET_BITS-1:0] offset);
         scan_verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result: found %0d match_offset %0d", found, offset);
            errors++;
            return;
         end
         v = pending_verdicts.pop_front();
         if (found !== v.found) begin
            $error("found: expected %0d, got %0d", v.found, found);
            errors++;
         end
         if (offset !== v.offset) begin
            $error("match_offset: expected %0d, got %0d", v.offset, offset);
            errors++;
         end
         if (v.found) found_count++;
         else missing_count++;
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [7:0]                             req_data_byte = 8'h00;
   logic                                   req_last_byte = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic                                   rsp_found;
   logic [bss_pkg::RESULT_OFFSET_BITS-1:0] rsp_match_offset;
   logic                                   csr_write_enable = 1'b0;
   logic [bss_pkg::CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [bss_pkg::CSR_DATA_BITS-1:0]      csr_write_data = '0;

   signature_tracker tracker = new();
   int               cycle_count = 0;
   int               items_sent = 0;
   int               images_sent = 0;
   int               phases_run = 0;
   int               burst_left = 0;
   logic [15:0]      stall_mask = 16'hFFFF;
   int               stall_timer = 0;

   byte_signature_scanner_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // request before result, so a prediction is always in place first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.predict_byte(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) tracker.check_verdict(rsp_found, rsp_match_offset);
      end
   end

   // receiver stalls on a rotating mask that is swapped now and then
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mask  <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         stall_timer <= $urandom_range(20, 200);
         rsp_ready   <= 1'b1;
      end else begin
         stall_timer <= stall_timer - 1;
         rsp_ready   <= stall_mask[0];
         stall_mask  <= {stall_mask[0], stall_mask[15:1]};
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
   endtask

   // hold off until every predicted result is out, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input bss_pkg::csr_index_type idx,
                            input logic [bss_pkg::CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      tracker.set_reg(idx, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_image(input logic [7:0] img [$]);
      images_sent++;
      foreach (img[i]) send_byte(img[i], i == img.size() - 1);
   endtask

   // mostly planted and broken signatures with noise in between
   task automatic run_image(input int target_len);
      logic [7:0] img [$];
      int         len;
      int         r;
      int         p;
      len = tracker.used_len();
      while (img.size() < target_len) begin
         r = $urandom_range(0, 9);
         if (r < 4) begin
            for (int j = 0; j < len; j++) img.push_back(tracker.sig_at(j));
         end else if (r < 6 && len > 1) begin
            p = $urandom_range(1, len - 1);
            for (int j = 0; j < p; j++) img.push_back(tracker.sig_at(j));
         end else if (r < 8) begin
            img.push_back(tracker.sig_at($urandom_range(0, len - 1)));
         end else begin
            img.push_back(8'($urandom));
         end
      end
      if ($urandom_range(0, 1) == 0) while (img.size() > target_len) void'(img.pop_back());
      send_image(img);
   endtask

   task automatic configure(input int kind);
      logic [8*bss_pkg::MAX_SIG_LEN-1:0] sig;
      logic [7:0]                        b0;
      logic [7:0]                        b1;
      int                                len_value;
      int                                skip_value;
      sig = {$urandom, $urandom, $urandom, $urandom};
      b0  = 8'($urandom);
      b1  = 8'($urandom);
      case (kind)
         0: begin len_value = 1; skip_value = 0; end
         1: begin len_value = bss_pkg::MAX_SIG_LEN; skip_value = $urandom_range(0, 3); end
         2: begin len_value = 0; skip_value = 255; sig[7:0] = b0; end
         3: begin
            len_value  = 31;
            skip_value = 1;
            sig = ($urandom_range(0, 1) == 0) ? {bss_pkg::MAX_SIG_LEN{b0}}
                                              : {(bss_pkg::MAX_SIG_LEN/2){b1, b0}};
         end
         4: begin len_value = $urandom_range(2, 15); skip_value = $urandom_range(0, 7); end
         default: begin
            len_value  = bss_pkg::MAX_SIG_LEN;
            skip_value = $urandom_range(0, 2);
            sig = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end
      endcase
      write_reg(bss_pkg::REG_SIG_LOW, sig[63:0]);
      write_reg(bss_pkg::REG_SIG_HIGH, sig[127:64]);
      // upper bits of the narrow registers carry junk
      write_reg(bss_pkg::REG_SIG_LENGTH, {32'($urandom), 27'($urandom), 5'(len_value)});
      write_reg(bss_pkg::REG_SKIP_COUNT, {32'($urandom), 24'($urandom), 8'(skip_value)});
   endtask

   function automatic int pick_len();
      int len;
      int r;
      len = tracker.used_len();
      r = $urandom_range(0, 9);
      if (r < 2) return $urandom_range(1, len);
      if (r < 9) return $urandom_range(len, 3 * len + 12);
      return $urandom_range(40, 80);
   endfunction

   initial begin
      logic [7:0] img [$];
      int         kind;
      int         phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default signature 1f 8b 08, length 3, no skip
      send_image('{8'h1f, 8'h8b, 8'h08});                              // match on the last byte
      send_image('{8'h1f});                                            // image shorter than signature
      send_image('{8'h00, 8'h1f, 8'h8b, 8'h08, 8'h1f, 8'h8b, 8'h08, 8'hff}); // bytes after the report
      send_image('{8'hff, 8'h00, 8'h1f, 8'h8b, 8'h00});                // broken signature
      send_image('{8'h1f, 8'h8b, 8'h1f, 8'h8b, 8'h08});                // overlapping start
      send_image('{8'h08});                                            // zero window must not match

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         kind = (phase < 6) ? phase : ($urandom_range(0, 1) ? 4 : 2 * $urandom_range(0, 2) + 1);
         if (kind == 6) kind = 0;
         drain();
         configure(kind);
         phases_run++;
         if (kind == 2) begin
            // one-byte signature: 256th hit is the one reported
            img.delete();
            repeat (300) img.push_back(tracker.sig_at(0));
            send_image(img);
            img.delete();
            repeat (120) img.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                   : tracker.sig_at(0));
            send_image(img);
         end else begin
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
               if ($urandom_range(0, 7) == 0) drain();
               run_image(pick_len());
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d results never arrived", tracker.pending());
         tracker.errors++;
      end
      $display("scanned %0d bytes in %0d images over %0d settings in %0d cycles",
               items_sent, images_sent, phases_run + 1, cycle_count);
      $display("signature located %0d times, absent %0d times",
               tracker.found_count, tracker.missing_count);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### byte_signature_scanner_top.f
+incdir+src
src/bss_pkg.sv
src/bss_csr.sv
src/bss_window.sv
src/byte_signature_scanner_top.sv
tb/tb_byte_signature_scanner_top.sv
